// ----- sv/tcss_pkg.sv -----
// shared types and constants for the cooling spray sequencer
package tcss_pkg;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_COOL  = 2'd1;
  localparam logic [1:0] PH_SPRAY = 2'd2;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  localparam logic [2:0] REG_COOLING_ENABLE   = 3'd0;
  localparam logic [2:0] REG_COOLING_MINUTES  = 3'd1;
  localparam logic [2:0] REG_SESSIONS_PER_DAY = 3'd2;
  localparam logic [2:0] REG_SPRAY_ENABLE     = 3'd3;
  localparam logic [2:0] REG_SPRAY_SECONDS    = 3'd4;

  localparam logic [7:0]  NO_SLOT     = 8'd255;
  localparam logic [5:0]  WINDOW_MIN  = 6'd5;
  localparam logic [4:0]  HOUR_NOON   = 5'd12;
  localparam logic [4:0]  HOUR_MORN   = 5'd8;
  localparam logic [4:0]  HOUR_EVE    = 5'd20;
  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic       operation;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [4:0] clock_day;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        heater_fan_override;
    logic        humidifier_override;
    logic [15:0] seconds_in_state;
    logic [13:0] cooling_remaining_s;
    logic [7:0]  last_slot_done;
  } out_t;

  // state stage result handed to the scaling stages
  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] elapsed_ms;
    logic [23:0] remain_ms;
    logic [7:0]  done_slot;
  } mid_t;

endpackage

// ----- sv/tcss_core.sv -----
// input register, configuration registers and session state update
module tcss_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  tcss_pkg::in_t     in_data,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              mid_valid,
  output tcss_pkg::mid_t    mid
);

  logic          cooling_enable;
  logic [7:0]    cooling_minutes;
  logic [1:0]    sessions_per_day;
  logic          spray_enable;
  logic [7:0]    spray_seconds;

  logic          in_v;
  tcss_pkg::in_t in_reg;

  logic [1:0]    phase;
  logic [31:0]   phase_start_ms;
  logic [4:0]    seen_day;
  logic [7:0]    done_slot;
  logic [7:0]    latched_cool_minutes;
  logic          latched_spray_on;
  logic [7:0]    latched_spray_seconds;

  logic [1:0]    phase_next;
  logic [7:0]    done_slot_next;
  logic          restart;
  logic          latch;
  logic          is_cancel;
  logic          day_change;
  logic [7:0]    done_eff;
  logic          disabled;
  logic          in_window;
  logic          slot;
  logic          slot_done;
  logic [31:0]   elapsed_old;
  logic [31:0]   elapsed_post;
  logic [23:0]   target_cool;
  logic [17:0]   target_spray;
  logic [7:0]    cool_min_next;
  logic [23:0]   target_post;
  logic [23:0]   remain_ms;
  logic [7:0]    finish_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooling_enable   <= 1'b0;
      cooling_minutes  <= 8'd0;
      sessions_per_day <= 2'd0;
      spray_enable     <= 1'b0;
      spray_seconds    <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcss_pkg::REG_COOLING_ENABLE:   cooling_enable   <= cfg_data[0];
        tcss_pkg::REG_COOLING_MINUTES:  cooling_minutes  <= cfg_data;
        tcss_pkg::REG_SESSIONS_PER_DAY: sessions_per_day <= cfg_data[1:0];
        tcss_pkg::REG_SPRAY_ENABLE:     spray_enable     <= cfg_data[0];
        tcss_pkg::REG_SPRAY_SECONDS:    spray_seconds    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_cancel   = (in_reg.operation == tcss_pkg::OP_CANCEL);
    day_change  = !is_cancel && (in_reg.clock_day != seen_day);
    done_eff    = day_change ? tcss_pkg::NO_SLOT : done_slot;
    disabled    = !cooling_enable || (cooling_minutes == 8'd0) || (sessions_per_day == 2'd0);
    elapsed_old = in_reg.now_ms - phase_start_ms;

    // selector three behaves as two slots a day
    if (sessions_per_day == 2'd1) begin
      in_window = (in_reg.clock_hour == tcss_pkg::HOUR_NOON);
      slot      = 1'b0;
    end else begin
      in_window = (in_reg.clock_hour == tcss_pkg::HOUR_MORN) ||
                  (in_reg.clock_hour == tcss_pkg::HOUR_EVE);
      slot      = (in_reg.clock_hour == tcss_pkg::HOUR_EVE);
    end
    in_window = in_window && (in_reg.clock_minute < tcss_pkg::WINDOW_MIN);
    slot_done = (done_eff != tcss_pkg::NO_SLOT) && ({7'd0, slot} <= done_eff);

    target_cool  = 24'(latched_cool_minutes * tcss_pkg::MS_PER_MIN);
    target_spray = 18'(latched_spray_seconds * tcss_pkg::MS_PER_S);
    finish_slot  = (done_eff == tcss_pkg::NO_SLOT) ? 8'd0 : done_eff + 8'd1;

    phase_next     = phase;
    done_slot_next = done_eff;
    restart        = 1'b0;
    latch          = 1'b0;

    if (is_cancel) begin
      phase_next = tcss_pkg::PH_IDLE;
      restart    = 1'b1;
    end else if (disabled) begin
      if (phase != tcss_pkg::PH_IDLE) begin
        phase_next = tcss_pkg::PH_IDLE;
        restart    = 1'b1;
      end
    end else begin
      unique case (phase)
        tcss_pkg::PH_IDLE: begin
          if (in_window && !slot_done) begin
            phase_next = tcss_pkg::PH_COOL;
            restart    = 1'b1;
            latch      = 1'b1;
          end
        end
        tcss_pkg::PH_COOL: begin
          if (elapsed_old >= {8'd0, target_cool}) begin
            restart = 1'b1;
            if (latched_spray_on && (latched_spray_seconds != 8'd0)) begin
              phase_next = tcss_pkg::PH_SPRAY;
            end else begin
              phase_next     = tcss_pkg::PH_IDLE;
              done_slot_next = finish_slot;
            end
          end
        end
        default: begin
          if (elapsed_old >= {14'd0, target_spray}) begin
            restart        = 1'b1;
            phase_next     = tcss_pkg::PH_IDLE;
            done_slot_next = finish_slot;
          end
        end
      endcase
    end

    elapsed_post  = restart ? 32'd0 : elapsed_old;
    cool_min_next = latch ? cooling_minutes : latched_cool_minutes;
    target_post   = 24'(cool_min_next * tcss_pkg::MS_PER_MIN);
    if ((phase_next == tcss_pkg::PH_COOL) && (elapsed_post < {8'd0, target_post})) begin
      remain_ms = target_post - elapsed_post[23:0];
    end else begin
      remain_ms = 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v                  <= 1'b0;
      mid_valid             <= 1'b0;
      phase                 <= tcss_pkg::PH_IDLE;
      phase_start_ms        <= 32'd0;
      seen_day              <= 5'd0;
      done_slot             <= tcss_pkg::NO_SLOT;
      latched_cool_minutes  <= 8'd0;
      latched_spray_on      <= 1'b0;
      latched_spray_seconds <= 8'd0;
    end else if (en) begin
      in_v      <= in_valid;
      mid_valid <= in_v;
      if (in_v) begin
        phase     <= phase_next;
        done_slot <= done_slot_next;
        if (day_change) begin
          seen_day <= in_reg.clock_day;
        end
        if (restart) begin
          phase_start_ms <= in_reg.now_ms;
        end
        if (latch) begin
          latched_cool_minutes  <= cooling_minutes;
          latched_spray_on      <= spray_enable;
          latched_spray_seconds <= spray_seconds;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_reg         <= in_data;
      mid.phase      <= phase_next;
      mid.elapsed_ms <= elapsed_post;
      mid.remain_ms  <= remain_ms;
      mid.done_slot  <= done_slot_next;
    end
  end

endmodule

// ----- sv/tcss_scale.sv -----
// millisecond to second conversion by reciprocal multiply, and the result register
module tcss_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            mid_valid,
  input  tcss_pkg::mid_t  mid,
  output logic            out_valid,
  output tcss_pkg::out_t  out_data
);

  logic        prod_v;
  logic [60:0] elapsed_prod;
  logic [52:0] remain_prod;
  logic [1:0]  prod_phase;
  logic [7:0]  prod_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      prod_v    <= mid_valid;
      out_valid <= prod_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elapsed_prod <= 61'(mid.elapsed_ms * tcss_pkg::RECIP_1000);
      remain_prod  <= 53'(mid.remain_ms * tcss_pkg::RECIP_1000);
      prod_phase   <= mid.phase;
      prod_done    <= mid.done_slot;

      out_data.mode                <= prod_phase;
      out_data.heater_fan_override <= (prod_phase == tcss_pkg::PH_COOL);
      out_data.humidifier_override <= (prod_phase == tcss_pkg::PH_SPRAY);
      out_data.seconds_in_state    <= elapsed_prod[tcss_pkg::RECIP_SHIFT +: 16];
      out_data.cooling_remaining_s <= remain_prod[tcss_pkg::RECIP_SHIFT +: 14];
      out_data.last_slot_done      <= prod_done;
    end
  end

endmodule

// ----- sv/timed_cooling_spray_sequencer_unit.sv -----
// top level of the daily cooling and spray session sequencer
// pipeline: an accepted request passes through in_reg, mid and the product registers to out_data
// throughput: one request per cycle; the whole pipeline stalls only while a result
//   waits on out_ready
// reset: synchronous rst clears the configuration, the session state and all valids
module timed_cooling_spray_sequencer_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tcss_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tcss_pkg::out_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [2:0]      cfg_index,
  input  logic [7:0]      cfg_data
);

  logic           en;
  logic           mid_valid;
  tcss_pkg::mid_t mid;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tcss_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  tcss_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mid_valid (mid_valid),
    .mid       (mid),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- sv/tcss_check.sv -----
// port level checks for the sequencer, bound to the top level
module tcss_check (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tcss_pkg::out_t out_data
);

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.heater_fan_override == (out_data.mode == tcss_pkg::PH_COOL) &&
                  out_data.humidifier_override == (out_data.mode == tcss_pkg::PH_SPRAY))
    else $error("override flags disagree with mode");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.mode != tcss_pkg::PH_COOL) |-> out_data.cooling_remaining_s == 14'd0)
    else $error("cooling time left outside cooling");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.mode == tcss_pkg::PH_IDLE) |-> !out_data.heater_fan_override)
    else $error("heater forced while idle");

  // an empty or draining output stage never blocks requests
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind timed_cooling_spray_sequencer_unit tcss_check u_tcss_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
